FILE: rtl/core/ctc_pkg.sv
// Shared types and constants of the CTC greedy decoder.
// Used by the front end, the event queue, the back end and the top level.
`timescale 1ns / 1ps
package ctc_pkg;

	// fixed field widths of the result item
	localparam int IDX_W   = 13;
	localparam int PROB_W  = 16;
	localparam int AVG_W   = 16;
	localparam int CNT_W   = 9;
	localparam int TDATA_W = 56;

	// result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_SUM  = 1'b1;

	// event queue depth (power of two)
	localparam int EVQ_DEPTH = 4;

	// divider: one quotient bit per cycle
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 5;

	// step-end event passed from front to back
	typedef struct packed {
		logic              is_char;
		logic              is_seq;
		logic [IDX_W-1:0]  char_index;
		logic [PROB_W-1:0] char_prob;
		logic [CNT_W-1:0]  char_count;
	} ev_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		BS_IDLE = 3'b001,
		BS_CHAR = 3'b010,
		BS_SUM  = 3'b100
	} bst_t;

endpackage

FILE: rtl/core/ctc_fe.sv
// Front end: per-step argmax, repeat/blank collapse, score sum and char count.
// Depends on ctc_pkg; pushes one event per emitted char or sequence end.
`timescale 1ns / 1ps
module ctc_fe import ctc_pkg::*; #(
	parameter int NUM_CLASSES = 8192,
	parameter int MAX_STEPS   = 256,
	parameter int PROB_BITS   = 16,
	parameter int CW          = $clog2(MAX_STEPS + 1),
	parameter int SW          = PROB_W + CW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,        // item accepted this cycle
	input  logic [PROB_W-1:0] prob,
	input  logic              class_end,
	input  logic              seq_end,
	output logic              push,
	output ev_t               ev,
	output logic [SW-1:0]     ev_sum,
	output logic [CW-1:0]     ev_cnt
);

	localparam int CPW = $clog2(NUM_CLASSES + 1);
	localparam int CLW = $clog2(NUM_CLASSES);
	localparam logic [PROB_W-1:0] PMASK = (PROB_BITS >= PROB_W) ? {PROB_W{1'b1}} :
		PROB_W'((64'd1 << PROB_BITS) - 64'd1);

	logic [CPW-1:0]    class_pos_q;
	logic [PROB_W-1:0] best_prob_q;
	logic [CLW-1:0]    best_class_q;
	logic [CLW-1:0]    prev_class_q;
	logic              first_step_q;
	logic [SW-1:0]     score_sum_q;
	logic [CW-1:0]     emit_count_q;

	logic [PROB_W-1:0] p;
	logic              in_range, take, step_end, emit;
	logic [PROB_W-1:0] nb_prob;
	logic [CLW-1:0]    nb_class;
	logic [CW-1:0]     emit_nx;
	logic [SW-1:0]     sum_nx;

	// argmax update, first maximum wins
	always_comb begin
		p        = prob & PMASK;
		in_range = class_pos_q < CPW'(NUM_CLASSES);
		take     = in_range && ((class_pos_q == '0) || (p > best_prob_q));
		nb_prob  = take ? p : best_prob_q;
		nb_class = take ? class_pos_q[CLW-1:0] : best_class_q;
		step_end = class_end | seq_end;
		emit     = step_end && (nb_class != '0)
			&& (first_step_q || (nb_class != prev_class_q))
			&& (emit_count_q < CW'(MAX_STEPS));
		emit_nx  = emit_count_q + CW'(1);
		sum_nx   = score_sum_q + SW'(nb_prob);
	end

	// event to the queue
	always_comb begin
		push          = acc && (emit || seq_end);
		ev.is_char    = emit;
		ev.is_seq     = seq_end;
		ev.char_index = IDX_W'(nb_class);
		ev.char_prob  = nb_prob;
		ev.char_count = CNT_W'(emit_nx);
		ev_sum        = emit ? sum_nx : score_sum_q;
		ev_cnt        = emit ? emit_nx : emit_count_q;
	end

	// per-step and per-sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_pos_q  <= '0;
			best_prob_q  <= '0;
			best_class_q <= '0;
			prev_class_q <= '0;
			first_step_q <= 1'b1;
			score_sum_q  <= '0;
			emit_count_q <= '0;
		end else if (acc) begin
			if (step_end) begin
				class_pos_q  <= '0;
				best_prob_q  <= '0;
				best_class_q <= '0;
				prev_class_q <= nb_class;
				first_step_q <= 1'b0;
			end else begin
				if (in_range)
					class_pos_q <= class_pos_q + CPW'(1);
				best_prob_q  <= nb_prob;
				best_class_q <= nb_class;
			end
			if (emit) begin
				emit_count_q <= emit_nx;
				score_sum_q  <= sum_nx;
			end
			if (seq_end) begin
				prev_class_q <= '0;
				first_step_q <= 1'b1;
				score_sum_q  <= '0;
				emit_count_q <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	ap_cls_sat: assert property (@(posedge clk) disable iff (!arst_n)
		class_pos_q <= CPW'(NUM_CLASSES))
		else $error("class position past saturation");
	ap_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		emit_count_q <= CW'(MAX_STEPS))
		else $error("char count past limit");
	ap_seq_clr: assert property (@(posedge clk) disable iff (!arst_n)
		acc && seq_end |=> (emit_count_q == '0) && (score_sum_q == '0) && first_step_q)
		else $error("sequence state not cleared after sequence end");
`endif

endmodule

FILE: rtl/core/ctc_evq.sv
// Short FIFO of step events between front end and back end.
// Depends on ctc_pkg for the depth; payload width set by the instance.
`timescale 1ns / 1ps
module ctc_evq import ctc_pkg::*; #(
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          empty
);

	localparam int AW  = $clog2(EVQ_DEPTH);
	localparam int NW  = $clog2(EVQ_DEPTH + 1);

	logic [DW-1:0] mem_q [EVQ_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;

	assign full  = cnt_q == NW'(EVQ_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + AW'(1);
			if (pop)
				rd_q <= rd_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + NW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - NW'(1);
		end
	end

`ifndef SYNTHESIS
	ap_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("event queue overflow");
	ap_no_udf: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("event queue underflow");
	ap_cnt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(EVQ_DEPTH))
		else $error("event queue count out of range");
`endif

endmodule

FILE: rtl/core/ctc_be.sv
// Back end: turns events into result items, runs the sequence-average divider.
// Depends on ctc_pkg; drives the registered result request.
`timescale 1ns / 1ps
module ctc_be import ctc_pkg::*; #(
	parameter int CW = 9,
	parameter int SW = PROB_W + CW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  ev_t                q_ev,
	input  logic [SW-1:0]      q_sum,
	input  logic [CW-1:0]      q_cnt,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_kind,
	output logic [TDATA_W-1:0] out_data,
	output logic               out_last
);

	bst_t st_q, st_nx;
	ev_t  ev_q;
	logic [CW-1:0] cnt_q;

	// divider: remainder, dividend/quotient shift register, step count
	logic [CW-1:0]        rem_q;
	logic [AVG_W-1:0]     dq_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CW:0]          shifted, diff;
	logic                 ge;

	// output register
	logic              ov_q;
	logic              o_kind_q;
	logic [IDX_W-1:0]  o_idx_q;
	logic [PROB_W-1:0] o_prob_q;
	logic [AVG_W-1:0]  o_avg_q;
	logic [CNT_W-1:0]  o_cnt_q;
	logic              o_empty_q;
	logic              o_last_q;

	logic out_free, ld_char, ld_sum, div_done;

	assign out_free = !ov_q || out_ready;
	assign div_done = div_cnt_q == '0;
	assign ld_char  = (st_q == BS_CHAR) && out_free;
	assign ld_sum   = (st_q == BS_SUM) && out_free && div_done;

	// fetch next event when idle or right after a lone char
	always_comb begin
		q_pop = !q_empty && ((st_q == BS_IDLE) || (ld_char && !ev_q.is_seq));
		st_nx = st_q;
		case (st_q)
			BS_IDLE: st_nx = BS_IDLE;
			BS_CHAR: begin
				if (ld_char)
					st_nx = ev_q.is_seq ? BS_SUM : BS_IDLE;
			end
			BS_SUM: begin
				if (ld_sum)
					st_nx = BS_IDLE;
			end
			default: st_nx = BS_IDLE;
		endcase
		if (q_pop)
			st_nx = q_ev.is_char ? BS_CHAR : BS_SUM;
	end

	// one restoring step
	always_comb begin
		shifted = {rem_q, dq_q[AVG_W-1]};
		ge      = shifted >= {1'b0, cnt_q};
		diff    = shifted - {1'b0, cnt_q};
	end

	// sequencer and divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= BS_IDLE;
			div_cnt_q <= '0;
		end else begin
			st_q <= st_nx;
			if (q_pop && q_ev.is_seq)
				div_cnt_q <= DIV_CNT_W'(DIV_STEPS);
			else if (!div_done)
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	// event and divider datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ev_q  <= q_ev;
			cnt_q <= q_cnt;
			if (q_ev.is_seq) begin
				rem_q <= q_sum[SW-1:AVG_W];
				dq_q  <= q_sum[AVG_W-1:0];
			end
		end else if (!div_done) begin
			rem_q <= ge ? diff[CW-1:0] : shifted[CW-1:0];
			dq_q  <= {dq_q[AVG_W-2:0], ge};
		end
	end

	// result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (ld_char || ld_sum)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (ld_char) begin
			o_kind_q  <= KIND_CHAR;
			o_idx_q   <= ev_q.char_index;
			o_prob_q  <= ev_q.char_prob;
			o_avg_q   <= '0;
			o_cnt_q   <= ev_q.char_count;
			o_empty_q <= 1'b0;
			o_last_q  <= 1'b0;
		end else if (ld_sum) begin
			o_kind_q  <= KIND_SUM;
			o_idx_q   <= '0;
			o_prob_q  <= '0;
			o_avg_q   <= (cnt_q == '0) ? '0 : dq_q;
			o_cnt_q   <= CNT_W'(cnt_q);
			o_empty_q <= cnt_q == '0;
			o_last_q  <= 1'b1;
		end
	end

	assign out_valid = ov_q;
	assign out_kind  = o_kind_q;
	assign out_last  = o_last_q;
	assign out_data  = {1'b0, o_empty_q, o_cnt_q, o_avg_q, o_prob_q, o_idx_q};

`ifndef SYNTHESIS
	ap_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && (o_kind_q == KIND_SUM) |-> o_last_q)
		else $error("summary result without last");
	ap_char_idx: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && (o_kind_q == KIND_CHAR) |-> (o_idx_q != '0) && !o_last_q)
		else $error("char result with blank index or last");
	ap_empty_avg: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && o_empty_q |-> (o_avg_q == '0) && (o_cnt_q == '0))
		else $error("empty summary with nonzero score or count");
	ap_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BS_IDLE) |-> div_done)
		else $error("divider running while back end idle");
`endif

endmodule

FILE: rtl/core/ctc_greedy_decoder_unit.sv
// Top level of the CTC greedy best-path decoder.
// Depends on ctc_pkg, ctc_fe, ctc_evq and ctc_be.
//
// Channel  Dir  Payload                                          Request when
// s_*      in   tdata: prob; tuser: class_end; tlast: seq_end    s_tvalid & s_tready
// m_*      out  tdata: char_index..empty_res; tuser: kind; tlast m_tvalid & m_tready
//
// The front end takes one class probability per cycle while the event queue
// (4 entries) has room. A character result is loaded into the output register
// once that is free; a summary also waits for the bit-serial divider to finish.
// Reset is asynchronous and active low and clears all control state.
// A stalled output fills the queue, which then drops s_tready.
`timescale 1ns / 1ps
module ctc_greedy_decoder_unit import ctc_pkg::*; #(
	parameter int NUM_CLASSES = 8192,
	parameter int MAX_STEPS   = 256,
	parameter int PROB_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [PROB_W-1:0]  s_tdata,   // [15:0] prob
	input  logic               s_tuser,   // [0] class_end
	input  logic               s_tlast,   // seq_end
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [12:0] char_index, [28:13] char_prob,
	                                      // [44:29] avg_score, [53:45] char_count,
	                                      // [54] empty_res, [55] zero
	output logic               m_tuser,   // [0] kind
	output logic               m_tlast    // last
);

	localparam int CW = $clog2(MAX_STEPS + 1);
	localparam int SW = PROB_W + CW;
	localparam int EW = $bits(ev_t);
	localparam int DW = SW + CW + EW;

	logic          acc, push, q_full, q_empty, q_pop;
	ev_t           fe_ev, be_ev;
	logic [SW-1:0] fe_sum, be_sum;
	logic [CW-1:0] fe_cnt, be_cnt;
	logic [DW-1:0] q_wdata, q_rdata;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;

	ctc_fe #(
		.NUM_CLASSES (NUM_CLASSES),
		.MAX_STEPS   (MAX_STEPS),
		.PROB_BITS   (PROB_BITS),
		.CW          (CW),
		.SW          (SW)
	) u_fe (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.prob      (s_tdata),
		.class_end (s_tuser),
		.seq_end   (s_tlast),
		.push      (push),
		.ev        (fe_ev),
		.ev_sum    (fe_sum),
		.ev_cnt    (fe_cnt)
	);

	assign q_wdata = {fe_sum, fe_cnt, fe_ev};

	ctc_evq #(
		.DW (DW)
	) u_evq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign be_ev  = q_rdata[EW-1:0];
	assign be_cnt = q_rdata[EW+CW-1:EW];
	assign be_sum = q_rdata[DW-1:EW+CW];

	ctc_be #(
		.CW (CW),
		.SW (SW)
	) u_be (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_ev      (be_ev),
		.q_sum     (be_sum),
		.q_cnt     (be_cnt),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

FILE: bench/tb.sv
// Self-checking bench for ctc_greedy_decoder_unit: directed table, long runs, random sequences.
// Depends on ctc_pkg and the decoder RTL; results are checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb;
	import ctc_pkg::*;

	localparam int N_CLASSES   = 8192;
	localparam int MAX_CHARS   = 256;
	localparam int RAND_ITEMS  = 600;
	localparam int HOLD_CYCLES = 250;
	localparam int WD_LIMIT    = 2000;
	localparam int DRAIN       = 40;

	// one result record, in the order fields are unpacked from the output bus
	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  char_index;
		logic [PROB_W-1:0] char_prob;
		logic [AVG_W-1:0]  avg_score;
		logic [CNT_W-1:0]  char_count;
		logic              empty_res;
		logic              last;
		logic              pad;
	} dec_res_t;

	// directed row; nexp < 0 means the predictor supplies the expectation
	typedef struct {
		logic [15:0] prob;
		bit          cend;
		bit          send;
		int          reps;
		int          nexp;
		dec_res_t    e0;
		dec_res_t    e1;
	} stim_row_t;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [PROB_W-1:0]  s_tdata  = '0;
	logic               s_tuser  = 1'b0;
	logic               s_tlast  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;

	// decoder shadow state
	int          cls_pos   = 0;
	logic [15:0] best_p    = '0;
	logic [12:0] best_c    = '0;
	logic [12:0] prev_c    = '0;
	bit          first_st  = 1'b1;
	logic [23:0] score_sum = '0;
	logic [8:0]  char_cnt  = '0;

	dec_res_t  exp_q[$];
	stim_row_t stim_tab[$];
	int        n_err     = 0;
	bit        tx_calm   = 1'b0;
	int        burst_left = 0;
	bit        hold_req  = 1'b0;

	ctc_greedy_decoder_unit #(
		.NUM_CLASSES(N_CLASSES),
		.MAX_STEPS(MAX_CHARS),
		.PROB_BITS(16)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic dec_res_t mk_res(logic k, logic [12:0] ci, logic [15:0] cp,
		logic [15:0] avg, logic [8:0] cnt, logic emp, logic lst);
		dec_res_t r;
		r = {k, ci, cp, avg, cnt, emp, lst, 1'b0};
		return r;
	endfunction

	function automatic string fmt_res(dec_res_t r);
		return $sformatf("kind=%0d idx=%0d prob=%h avg=%h cnt=%0d empty=%0d last=%0d pad=%0d",
			r.kind, r.char_index, r.char_prob, r.avg_score, r.char_count,
			r.empty_res, r.last, r.pad);
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// probability mix: extremes, small tie-prone values, full range
	function automatic logic [15:0] rand_prob();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 16'h0000;
		else if (r == 1)
			return 16'hFFFF;
		else if (r == 2)
			return 16'($urandom_range(0, 3));
		return 16'($urandom);
	endfunction

	function automatic void add_row(logic [15:0] p, bit ce, bit se, int reps,
		int nexp = -1, dec_res_t e0 = '0, dec_res_t e1 = '0);
		stim_row_t row;
		row.prob = p;
		row.cend = ce;
		row.send = se;
		row.reps = reps;
		row.nexp = nexp;
		row.e0   = e0;
		row.e1   = e1;
		stim_tab = {stim_tab, row};
	endfunction

	// greedy best-path step: argmax per time step, collapse repeats, summary per sequence
	function automatic int decode_item(logic [15:0] p, bit ce, bit se,
		output dec_res_t r0, output dec_res_t r1);
		int          n;
		logic [12:0] c;
		logic [23:0] avg;
		dec_res_t    r [2];
		n = 0;
		r[0] = '0;
		r[1] = '0;
		if (cls_pos < N_CLASSES) begin
			if (cls_pos == 0 || p > best_p) begin
				best_p = p;
				best_c = 13'(cls_pos);
			end
			cls_pos++;
		end
		if (ce || se) begin
			c = best_c;
			if (c != 0 && (first_st || c != prev_c) && char_cnt < MAX_CHARS) begin
				char_cnt++;
				score_sum += 24'(best_p);
				r[n] = mk_res(KIND_CHAR, c, best_p, '0, char_cnt, 1'b0, 1'b0);
				n++;
			end
			prev_c   = c;
			first_st = 1'b0;
			cls_pos  = 0;
			best_p   = '0;
			best_c   = '0;
		end
		if (se) begin
			avg = (char_cnt != 0) ? score_sum / 24'(char_cnt) : '0;
			r[n] = mk_res(KIND_SUM, '0, '0, avg[15:0], char_cnt, char_cnt == 0, 1'b1);
			n++;
			prev_c    = '0;
			first_st  = 1'b1;
			score_sum = '0;
			char_cnt  = '0;
		end
		r0 = r[0];
		r1 = r[1];
		return n;
	endfunction

	// offer one request, wait for acceptance, then queue its expected results
	task automatic send_checked(logic [15:0] p, bit ce, bit se,
		int nexp = -1, dec_res_t e0 = '0, dec_res_t e1 = '0);
		int       g;
		int       n;
		dec_res_t r0, r1;
		g = (tx_calm || burst_left > 0) ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		s_tuser  <= ce;
		s_tlast  <= se;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (burst_left > 0)
			burst_left--;
		n = decode_item(p, ce, se, r0, r1);
		if (nexp >= 0) begin
			n  = nexp;
			r0 = e0;
			r1 = e1;
		end
		if (n > 0)
			exp_q = {exp_q, r0};
		if (n > 1)
			exp_q = {exp_q, r1};
	endtask

	// output side: random stalls, calm windows, and one long hold-off on request
	initial begin : receiver
		int hold_left;
		int stall_left;
		int cyc;
		hold_left  = 0;
		stall_left = 0;
		cyc        = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if ((cyc / 400) % 3 != 0 && $urandom_range(0, 2) == 0)
					stall_left = gap_len();
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		dec_res_t got;
		dec_res_t want;
		if (m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[12:0], m_tdata[28:13], m_tdata[44:29],
				m_tdata[53:45], m_tdata[54], m_tlast, m_tdata[55]};
			if (exp_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected result: %s", fmt_res(got));
			end else begin
				want = exp_q.pop_front();
				if (got != want) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch:\n  exp %s\n  got %s", fmt_res(want), fmt_res(got));
				end
			end
		end
	end

	// ends the run when no request moves on either side for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WD_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("tb: errors");
		$finish;
	end

	initial begin : stimulus
		int       n_rand;
		int       n_steps;
		int       n_cls;
		int       w;
		int       pw;
		bit       ce;
		bit       se;
		bit       pressed;
		bit       paused;
		logic [15:0] pr [3];

		// empty sequence straight after reset
		add_row(16'h0000, 1, 1, 1, 1, mk_res(KIND_SUM, 0, 0, 0, 0, 1, 1));
		// one character at full scale
		add_row(16'h0000, 0, 0, 1, 0);
		add_row(16'hFFFF, 1, 1, 1, 2, mk_res(KIND_CHAR, 1, 16'hFFFF, 0, 1, 0, 0),
			mk_res(KIND_SUM, 0, 0, 16'hFFFF, 1, 0, 1));
		// tie: first maximum wins
		add_row(16'd7, 0, 0, 1);
		add_row(16'd9, 0, 0, 1);
		add_row(16'd9, 1, 0, 1);
		// repeated class collapses
		add_row(16'd0, 0, 0, 1);
		add_row(16'd8, 1, 0, 1);
		// blank step separates two like classes
		add_row(16'd5, 1, 0, 1);
		add_row(16'd0, 0, 0, 1);
		add_row(16'd3, 1, 0, 1);
		// sequence end closes the step without a class end
		add_row(16'd1, 0, 0, 1);
		add_row(16'd0, 0, 0, 1);
		add_row(16'd4, 0, 1, 1);
		// first step of a new sequence emits even if it matches the old last class
		add_row(16'd0, 0, 0, 1);
		add_row(16'd0, 0, 0, 1);
		add_row(16'd6, 1, 1, 1);
		// highest class index wins
		add_row(16'd1, 0, 0, N_CLASSES - 1);
		add_row(16'hFFFF, 1, 0, 1, 1, mk_res(KIND_CHAR, 13'h1FFF, 16'hFFFF, 0, 1, 0, 0));
		// classes past the last index are ignored; the step resolves to blank
		add_row(16'd5, 0, 0, N_CLASSES);
		add_row(16'hFFFF, 1, 1, 1, 1, mk_res(KIND_SUM, 0, 0, 16'hFFFF, 1, 0, 1));
		// all-zero step is blank; sequence empty
		add_row(16'd0, 0, 0, 1);
		add_row(16'd0, 1, 1, 1, 1, mk_res(KIND_SUM, 0, 0, 0, 0, 1, 1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_tab[i]) begin
			for (int k = 0; k < stim_tab[i].reps; k++)
				send_checked(stim_tab[i].prob, stim_tab[i].cend, stim_tab[i].send,
					stim_tab[i].nexp, stim_tab[i].e0, stim_tab[i].e1);
		end

		// overlong sequence: classes 1 and 2 alternate so every step emits until the cap
		for (int s = 0; s < MAX_CHARS + 4; s++) begin
			if (s % 32 == 0)
				tx_calm = ($urandom_range(0, 2) == 0);
			w     = (s % 2) + 1;
			pw    = $urandom_range(1, 65535);
			pr[0] = 16'($urandom_range(0, pw - 1));
			pr[1] = 16'($urandom_range(0, pw - 1));
			pr[2] = 16'($urandom_range(0, pw - 1));
			pr[w] = 16'(pw);
			for (int c = 0; c < 3; c++)
				send_checked(pr[c], c == 2, (c == 2) && (s == MAX_CHARS + 3));
		end

		// random sequences, mostly well formed with a little noise in the flags
		n_rand  = 0;
		pressed = 1'b0;
		paused  = 1'b0;
		while (n_rand < RAND_ITEMS) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			if (!pressed && n_rand > 150) begin
				pressed    = 1'b1;
				hold_req   = 1'b1;
				burst_left = 80;
			end
			if (pressed && !paused && burst_left == 0) begin
				// let the block drain completely before going on
				paused = 1'b1;
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (exp_q.size() != 0) @(posedge clk);
			end
			n_steps = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			for (int s = 0; s < n_steps; s++) begin
				n_cls = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
				for (int c = 0; c < n_cls; c++) begin
					ce = (c == n_cls - 1);
					se = ce && (s == n_steps - 1);
					if (se && $urandom_range(0, 2) == 0)
						ce = 1'b0;
					if ($urandom_range(0, 39) == 0)
						ce = !ce;
					if ($urandom_range(0, 79) == 0)
						se = 1'b1;
					send_checked(rand_prob(), ce, se);
					n_rand++;
				end
			end
		end

		s_tvalid <= 1'b0;
		while (exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (n_err == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
